### design/ascii_decimal_triple_line_parser_unit_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the triple line parser
// Concurrent checks that compile away when SYNTH is defined.
// ---------------------------------------------------------------------------
`ifndef ASCII_DECIMAL_TRIPLE_LINE_PARSER_UNIT_MACROS_SVH
`define ASCII_DECIMAL_TRIPLE_LINE_PARSER_UNIT_MACROS_SVH

`ifndef SYNTH
// Same-cycle implication, checked at every rising edge outside reset.
`define ADTLP_ASSERT_IMP(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("parser check failed: same-cycle implication");
// Next-cycle implication, checked at every rising edge outside reset.
`define ADTLP_ASSERT_NXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("parser check failed: next-cycle implication");
`else
`define ADTLP_ASSERT_IMP(lbl, ck, rs, ante, cons)
`define ADTLP_ASSERT_NXT(lbl, ck, rs, ante, cons)
`endif

`endif

### design/adtlp_pkg.sv
// ---------------------------------------------------------------------------
// Triple line parser package
// Shared types and constants for the front classifier, queue and back end.
// ---------------------------------------------------------------------------
package adtlp_pkg;

  localparam int DEFAULT_LINE_CAPACITY = 64;
  localparam int QUEUE_DEPTH           = 2;
  localparam int VALUE_W               = 16;
  localparam int NUM_FIELDS            = 3;
  localparam int COUNT_W               = 2;
  localparam int RESULT_W              = 56;

  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_VT    = 8'h0B;
  localparam logic [7:0] CHAR_FF    = 8'h0C;
  localparam logic [7:0] CHAR_COMMA = 8'h2C;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  localparam logic [VALUE_W-1:0] VALUE_MAX = 16'hFFFF;

  typedef enum logic [2:0] {
    KIND_DIGIT = 3'd0,
    KIND_BLANK = 3'd1,
    KIND_COMMA = 3'd2,
    KIND_TERM  = 3'd3,
    KIND_OTHER = 3'd4
  } byte_kind_t;

  typedef struct packed {
    byte_kind_t  kind;
    logic [3:0]  digit;
  } rx_class_t;

  typedef struct packed {
    logic      valid;
    rx_class_t item;
  } queue_head_t;

endpackage

### design/adtlp_front.sv
// ---------------------------------------------------------------------------
// Triple line parser front end
// Classifies each received byte and pushes the class into the queue.
// ---------------------------------------------------------------------------
module adtlp_front (
  input  logic               s_tvalid,
  input  logic [7:0]         s_tdata,    // [7:0] rx_byte
  input  logic               queue_full,
  output logic               s_tready,
  output logic               push,
  output adtlp_pkg::rx_class_t push_item
);
  import adtlp_pkg::*;

  assign s_tready = !queue_full;
  assign push     = s_tvalid && !queue_full;

  always_comb begin
    push_item.digit = s_tdata[3:0];
    if (s_tdata == CHAR_LF || s_tdata == CHAR_CR) begin
      push_item.kind = KIND_TERM;
    end else if (s_tdata >= CHAR_ZERO && s_tdata <= CHAR_NINE) begin
      push_item.kind = KIND_DIGIT;
    end else if (s_tdata == CHAR_SPACE || s_tdata == CHAR_TAB ||
                 s_tdata == CHAR_VT || s_tdata == CHAR_FF) begin
      push_item.kind = KIND_BLANK;
    end else if (s_tdata == CHAR_COMMA) begin
      push_item.kind = KIND_COMMA;
    end else begin
      push_item.kind = KIND_OTHER;
    end
  end

endmodule

### design/adtlp_queue.sv
// ---------------------------------------------------------------------------
// Triple line parser queue
// Short register queue that decouples the classifier from the back end.
// ---------------------------------------------------------------------------
module adtlp_queue (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  adtlp_pkg::rx_class_t   push_item,
  input  logic                   pop,
  output logic                   full,
  output adtlp_pkg::queue_head_t head
);
  import adtlp_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  rx_class_t        entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full       = (count == CNT_W'(QUEUE_DEPTH));
  assign head.valid = (count != '0);
  assign head.item  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

### design/adtlp_back.sv
// ---------------------------------------------------------------------------
// Triple line parser back end
// Runs the per-line field parse and holds the result for the master side.
// ---------------------------------------------------------------------------
`include "ascii_decimal_triple_line_parser_unit_macros.svh"

module adtlp_back #(
  parameter int LINE_CAPACITY = adtlp_pkg::DEFAULT_LINE_CAPACITY
) (
  input  logic                          clk,
  input  logic                          rst,
  input  adtlp_pkg::queue_head_t        head,
  output logic                          pop,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [adtlp_pkg::RESULT_W-1:0] m_tdata
);
  import adtlp_pkg::*;

  localparam int LEN_W = $clog2(LINE_CAPACITY);

  logic [1:0]         fidx, fidx_next;
  logic               failed, failed_next;
  logic               seen, seen_next;
  logic [VALUE_W-1:0] acc, acc_next;
  logic [LEN_W-1:0]   len, len_next;
  logic [VALUE_W-1:0] pending [NUM_FIELDS];
  logic [VALUE_W-1:0] pending_next [NUM_FIELDS];
  logic [VALUE_W-1:0] held [NUM_FIELDS];
  logic [VALUE_W-1:0] held_next [NUM_FIELDS];
  logic [COUNT_W-1:0] conv, conv_next;
  logic               m_tvalid_next;
  logic               is_term;
  logic               term_pop;
  logic [19:0]        acc_wide;

  assign is_term  = (head.item.kind == KIND_TERM);
  // A terminator needs a free output slot; other bytes never block.
  assign pop      = head.valid && (!is_term || !m_tvalid || m_tready);
  assign term_pop = pop && is_term;

  assign acc_wide = (20'(acc) << 3) + (20'(acc) << 1) + 20'(head.item.digit);

  always_comb begin
    fidx_next     = fidx;
    failed_next   = failed;
    seen_next     = seen;
    acc_next      = acc;
    len_next      = len;
    conv_next     = conv;
    pending_next  = pending;
    held_next     = held;
    m_tvalid_next = m_tready ? 1'b0 : m_tvalid;

    if (term_pop) begin
      if (!failed && seen && fidx != 2'd3) begin
        for (int k = 0; k < NUM_FIELDS; k++) begin
          if (fidx == 2'(k)) begin
            pending_next[k] = acc;
          end
        end
        fidx_next = fidx + 1'b1;
      end
      for (int k = 0; k < NUM_FIELDS; k++) begin
        if (2'(k) < fidx_next) begin
          held_next[k] = pending_next[k];
        end
      end
      conv_next     = fidx_next;
      m_tvalid_next = 1'b1;
      fidx_next     = '0;
      failed_next   = 1'b0;
      seen_next     = 1'b0;
      acc_next      = '0;
      len_next      = '0;
    end else if (pop) begin
      if (!failed && fidx != 2'd3) begin
        if (head.item.kind == KIND_DIGIT) begin
          acc_next  = (acc_wide > 20'(VALUE_MAX)) ? VALUE_MAX : acc_wide[VALUE_W-1:0];
          seen_next = 1'b1;
        end else if (!seen && head.item.kind == KIND_BLANK) begin
          // leading blank before the first digit of a field is skipped
        end else if (seen && head.item.kind == KIND_COMMA && fidx < 2'd2) begin
          for (int k = 0; k < NUM_FIELDS; k++) begin
            if (fidx == 2'(k)) begin
              pending_next[k] = acc;
            end
          end
          fidx_next = fidx + 1'b1;
          seen_next = 1'b0;
          acc_next  = '0;
        end else begin
          if (seen) begin
            for (int k = 0; k < NUM_FIELDS; k++) begin
              if (fidx == 2'(k)) begin
                pending_next[k] = acc;
              end
            end
            fidx_next = fidx + 1'b1;
            seen_next = 1'b0;
            acc_next  = '0;
          end
          failed_next = 1'b1;
        end
      end
      if (len == LEN_W'(LINE_CAPACITY - 1)) begin
        // Line overran its capacity: start again from empty.
        fidx_next   = '0;
        failed_next = 1'b0;
        seen_next   = 1'b0;
        acc_next    = '0;
        len_next    = '0;
      end else begin
        len_next = len + 1'b1;
      end
    end
  end

  // Pending values are written before they are ever copied out, so they
  // carry no reset.
  always_ff @(posedge clk) begin
    pending <= pending_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fidx     <= '0;
      failed   <= 1'b0;
      seen     <= 1'b0;
      acc      <= '0;
      len      <= '0;
      conv     <= '0;
      m_tvalid <= 1'b0;
      for (int k = 0; k < NUM_FIELDS; k++) begin
        held[k] <= '0;
      end
    end else begin
      fidx     <= fidx_next;
      failed   <= failed_next;
      seen     <= seen_next;
      acc      <= acc_next;
      len      <= len_next;
      conv     <= conv_next;
      m_tvalid <= m_tvalid_next;
      held     <= held_next;
    end
  end

  assign m_tdata = {6'b0, conv, held[2], held[1], held[0]};

  `ADTLP_ASSERT_IMP(a_fail_clears_digit, clk, rst, failed, !seen)
  `ADTLP_ASSERT_IMP(a_third_done_idle, clk, rst, fidx == 2'd3, !seen)
  `ADTLP_ASSERT_IMP(a_result_from_term, clk, rst, $rose(m_tvalid), $past(term_pop))
  `ADTLP_ASSERT_NXT(a_stall_holds_values, clk, rst, m_tvalid && !m_tready,
                    $stable(conv) && $stable(held[0]) && $stable(held[2]))

endmodule

### design/ascii_decimal_triple_line_parser_unit.sv
// ---------------------------------------------------------------------------
// ASCII decimal triple line parser
// Parses lines "number,number,number" from a byte stream into three values.
// ---------------------------------------------------------------------------
// A terminator byte is registered in the queue, then its result in the output register.
// Throughput: one byte per cycle while the queue is not full; a terminator
// waits only while the previous result is not taken.
// Reset (rst, synchronous, active high) empties the queue, clears the line
// state and sets all three held values to zero; no result is pending after it.
module ascii_decimal_triple_line_parser_unit #(
  parameter int LINE_CAPACITY = adtlp_pkg::DEFAULT_LINE_CAPACITY
) (
  input  logic                           clk,
  input  logic                           rst,
  // Slave side: one received byte per transfer.
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [7:0]                     s_tdata,  // [7:0] rx_byte
  // Master side: one result transfer per line terminator.
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // [15:0] temperature, [31:16] speed_value, [47:32] fuel_level,
  // [49:48] fields_converted, [55:50] zero
  output logic [adtlp_pkg::RESULT_W-1:0] m_tdata
);
  import adtlp_pkg::*;

  // The front classifies each byte (digit, blank, comma, terminator, other)
  // so the back end only sees a small code and the digit value.
  logic        push;
  logic        pop;
  logic        queue_full;
  rx_class_t   push_item;
  queue_head_t head;

  adtlp_front u_front (
    .s_tvalid   (s_tvalid),
    .s_tdata    (s_tdata),
    .queue_full (queue_full),
    .s_tready   (s_tready),
    .push       (push),
    .push_item  (push_item)
  );

  // The queue lets the front keep taking bytes while a terminator waits
  // in the back end for the output register to drain.
  adtlp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .full      (queue_full),
    .head      (head)
  );

  // The back end holds the per-line parse state and the three held values;
  // the output register is the held values themselves plus the field count.
  adtlp_back #(
    .LINE_CAPACITY (LINE_CAPACITY)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

### sim/testbench.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Testbench for the ASCII decimal triple line parser
// Streams text lines, parses them again in the bench and checks each result.
// ---------------------------------------------------------------------------
// An initial block builds a queue of bytes: a few hand-written lines first,
// then random lines that are mostly well formed, some broken on purpose,
// some pure noise and a few that overrun the line capacity. A driver on the
// falling edge offers the bytes, a receiver on the falling edge toggles
// m_tready, and one block on the rising edge predicts, checks and keeps the
// watchdog. Twice the receiver holds off long enough to back the parser up,
// and every so often the sender waits until all lines in flight are back.
module testbench;
  import adtlp_pkg::*;

  localparam int LINE_CAP       = DEFAULT_LINE_CAPACITY;
  localparam int BYTE_TARGET    = 1250;
  localparam int TAIL_BYTES     = 120;
  localparam int LONG_HOLD      = 160;
  localparam int HOLD_SPACING   = 400;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int SETTLE_CYCLES  = 8;

  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;

  typedef enum logic {
    ITEM_BYTE,
    ITEM_DRAIN
  } stim_kind_t;

  typedef struct packed {
    stim_kind_t kind;
    logic [7:0] ch;
  } stim_item_t;

  // Layout of m_tdata, most significant member first.
  typedef struct packed {
    logic [5:0]  pad;
    logic [1:0]  fields_converted;
    logic [15:0] fuel_level;
    logic [15:0] speed_value;
    logic [15:0] temperature;
  } line_result_t;

  logic                clk;
  logic                rst;
  logic                s_tvalid;
  logic                s_tready;
  logic [7:0]          s_tdata;   // [7:0] rx_byte
  logic                m_tvalid;
  logic                m_tready;
  // [15:0] temperature, [31:16] speed_value, [47:32] fuel_level,
  // [49:48] fields_converted, [55:50] zero
  logic [RESULT_W-1:0] m_tdata;

  ascii_decimal_triple_line_parser_unit uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Bytes still to send and lines whose results are still on their way.
  stim_item_t   text_q[$];
  line_result_t results_due[$];

  int total_bytes;
  int lines_built;
  int bytes_in;
  int results_seen;
  int fail_count;
  int quiet_cycles;
  int conv_hist[4];
  bit byte_taken;

  // Shadow copy of the parser state.
  logic [1:0]  fld_idx;
  logic        conv_stopped;
  logic        have_digit;
  logic [15:0] acc;
  logic [15:0] held[3];
  logic [15:0] pend[3];
  int          line_len;

  // Sender and receiver pacing.
  int send_gap;
  int send_calm;
  bit waiting_drain;
  int recv_gap;
  int recv_calm;
  int hold_left;
  int holds_done;

  function automatic void clear_line();
    fld_idx      = '0;
    conv_stopped = 1'b0;
    have_digit   = 1'b0;
    acc          = '0;
    line_len     = 0;
    pend[0]      = '0;
    pend[1]      = '0;
    pend[2]      = '0;
  endfunction

  function automatic void close_field();
    if (fld_idx < 2'd3) begin
      pend[fld_idx] = acc;
      fld_idx       = fld_idx + 2'd1;
    end
    have_digit = 1'b0;
    acc        = '0;
  endfunction

  // Advances the shadow parser by one byte. Returns 1 when the byte ends a
  // line, with the result the parser has to send for it.
  function automatic bit parse_byte(input logic [7:0] ch, output line_result_t res);
    logic [19:0] grown;
    res = '0;
    if (ch == CHAR_LF || ch == CHAR_CR) begin
      if (!conv_stopped && have_digit && fld_idx < 2'd3) close_field();
      for (int k = 0; k < 3; k++) begin
        if (k < fld_idx) held[k] = pend[k];
      end
      res.temperature      = held[0];
      res.speed_value      = held[1];
      res.fuel_level       = held[2];
      res.fields_converted = fld_idx;
      clear_line();
      return 1'b1;
    end
    if (!conv_stopped && fld_idx < 2'd3) begin
      if (ch >= CHAR_ZERO && ch <= CHAR_NINE) begin
        // Decimal accumulation that sticks at the top of the 16-bit range.
        grown      = {4'd0, acc} * 20'd10 + {12'd0, ch - CHAR_ZERO};
        acc        = (grown > {4'd0, VALUE_MAX}) ? VALUE_MAX : grown[15:0];
        have_digit = 1'b1;
      end else if (!have_digit && (ch == CHAR_SPACE || ch == CHAR_TAB ||
                                   ch == CHAR_VT || ch == CHAR_FF)) begin
        // Blanks ahead of the first digit of a field are skipped.
      end else if (have_digit && ch == CHAR_COMMA && fld_idx < 2'd2) begin
        close_field();
      end else begin
        // Anything else ends conversion; digits already seen still count.
        if (have_digit) close_field();
        conv_stopped = 1'b1;
      end
    end
    line_len++;
    if (line_len >= LINE_CAP) clear_line();
    return 1'b0;
  endfunction

  task automatic add_byte(input logic [7:0] ch);
    text_q.push_back('{kind: ITEM_BYTE, ch: ch});
    total_bytes++;
  endtask

  task automatic add_text(input string s);
    for (int k = 0; k < s.len(); k++) add_byte(s[k]);
  endtask

  function automatic logic [7:0] any_blank();
    case ($urandom_range(0, 3))
      0:       return CHAR_SPACE;
      1:       return CHAR_TAB;
      2:       return CHAR_VT;
      default: return CHAR_FF;
    endcase
  endfunction

  // One field: a few leading blanks, then usually some digits. Long digit
  // strings are rare so that most values stay in range.
  task automatic add_field(input bit with_digits);
    int n_blank;
    int n_digit;
    n_blank = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0;
    n_digit = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 7) : $urandom_range(1, 3);
    repeat (n_blank) add_byte(any_blank());
    if (with_digits) begin
      repeat (n_digit) add_byte(CHAR_ZERO + 8'($urandom_range(0, 9)));
    end
  endtask

  // Builds the whole byte stream before reset is released.
  task automatic build_text();
    int pick;
    int spoil_at;
    int spoil_how;
    int n_fields;
    // Directed: empty line, a saturating first field with a zero and a
    // plain value, blanks of every kind before a field and a sign after a
    // comma, then a NUL and an FF byte.
    add_byte(CHAR_LF);
    add_text("99999,0,7");
    add_byte(CHAR_CR);
    add_byte(CHAR_SPACE);
    add_byte(CHAR_TAB);
    add_byte(CHAR_VT);
    add_byte(CHAR_FF);
    add_text("5,-1");
    add_byte(CHAR_LF);
    add_byte(8'h00);
    add_byte(8'hFF);
    add_byte(CHAR_CR);
    while (total_bytes < BYTE_TARGET) begin
      lines_built++;
      if (lines_built % 25 == 0) text_q.push_back('{kind: ITEM_DRAIN, ch: 8'h00});
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        // Well formed, sometimes short of fields or with junk at the end.
        n_fields = (pick < 55) ? 3 : $urandom_range(1, 2);
        for (int f = 0; f < n_fields; f++) begin
          add_field(1'b1);
          if (f < n_fields - 1) add_byte(CHAR_COMMA);
        end
        if ($urandom_range(0, 5) == 0) begin
          repeat ($urandom_range(1, 3)) add_byte(8'($urandom_range(0, 255)));
        end
      end else if (pick < 85) begin
        // One field spoiled: no digits, a sign, a blank before the comma,
        // or some other byte where the comma belongs.
        spoil_at  = $urandom_range(0, 2);
        spoil_how = $urandom_range(0, 3);
        for (int f = 0; f < 3; f++) begin
          if (f == spoil_at && spoil_how == 1) begin
            add_byte($urandom_range(0, 1) ? CHAR_PLUS : CHAR_MINUS);
          end
          add_field(!(f == spoil_at && spoil_how == 0));
          if (f == spoil_at && spoil_how == 2) add_byte(CHAR_SPACE);
          if (f < 2) begin
            add_byte((f == spoil_at && spoil_how == 3) ? 8'($urandom_range(0, 255))
                                                       : CHAR_COMMA);
          end
        end
      end else if (pick < 96) begin
        repeat ($urandom_range(1, 8)) add_byte(8'($urandom_range(0, 255)));
      end else begin
        // Overlong line around the capacity so the restart is crossed.
        repeat ($urandom_range(LINE_CAP - 4, LINE_CAP + 12)) begin
          case ($urandom_range(0, 5))
            0:       add_byte(CHAR_COMMA);
            1:       add_byte(CHAR_SPACE);
            default: add_byte(CHAR_ZERO + 8'($urandom_range(0, 9)));
          endcase
        end
      end
      add_byte($urandom_range(0, 1) ? CHAR_LF : CHAR_CR);
    end
  endtask

  // Sender: holds a byte until it is taken, otherwise idles in short bursts,
  // waits at drain points, or offers the next byte. Nothing is offered in
  // reset.
  always @(negedge clk) begin
    stim_item_t it;
    logic       offer;
    logic [7:0] data;
    offer = s_tvalid && !byte_taken;
    data  = s_tdata;
    if (rst) begin
      offer = 1'b0;
    end else if (!offer) begin
      if (send_calm != 0) send_calm--;
      else if ($urandom_range(0, 49) == 0) send_calm = $urandom_range(20, 60);
      if (send_gap != 0) begin
        send_gap--;
      end else if (bytes_in + TAIL_BYTES < total_bytes && send_calm == 0 &&
                   $urandom_range(0, 4) == 0) begin
        send_gap = $urandom_range(0, 3);
      end else if (waiting_drain) begin
        waiting_drain = (results_due.size() != 0);
      end else if (text_q.size() != 0) begin
        it = text_q.pop_front();
        if (it.kind == ITEM_DRAIN) begin
          waiting_drain = 1'b1;
        end else begin
          offer = 1'b1;
          data  = it.ch;
        end
      end
    end
    s_tvalid <= offer;
    s_tdata  <= data;
  end

  // Receiver: two long hold-offs while bytes keep coming, short stalls the
  // rest of the time, none near the end.
  always @(negedge clk) begin
    logic rdy;
    rdy = 1'b1;
    if (rst) begin
      rdy = 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      rdy = 1'b0;
    end else if (holds_done < 2 && bytes_in >= (holds_done + 1) * HOLD_SPACING) begin
      hold_left = LONG_HOLD - 1;
      holds_done++;
      rdy = 1'b0;
    end else begin
      if (recv_calm != 0) recv_calm--;
      else if ($urandom_range(0, 49) == 0) recv_calm = $urandom_range(20, 60);
      if (recv_gap != 0) begin
        recv_gap--;
        rdy = 1'b0;
      end else if (bytes_in + TAIL_BYTES < total_bytes && recv_calm == 0 &&
                   $urandom_range(0, 4) == 0) begin
        recv_gap = $urandom_range(0, 3);
        rdy      = 1'b0;
      end
    end
    m_tready <= rdy;
  end

  // Checks results against the oldest prediction, then predicts from the
  // byte taken at this edge. Results always trail their terminator, so the
  // check comes first. Reset clears the shadow parser.
  always @(posedge clk) begin
    line_result_t got;
    line_result_t want;
    line_result_t predicted;
    byte_taken = !rst && s_tvalid && s_tready;
    if (rst) begin
      clear_line();
      for (int k = 0; k < 3; k++) held[k] = '0;
    end else begin
      if (m_tvalid && m_tready) begin
        got = m_tdata;
        results_seen++;
        if (results_due.size() == 0) begin
          $error("result with no line pending: %h", m_tdata);
          fail_count++;
        end else begin
          want = results_due.pop_front();
          if (got.temperature != want.temperature) begin
            $error("temperature: expected %0d, got %0d", want.temperature, got.temperature);
            fail_count++;
          end
          if (got.speed_value != want.speed_value) begin
            $error("speed_value: expected %0d, got %0d", want.speed_value, got.speed_value);
            fail_count++;
          end
          if (got.fuel_level != want.fuel_level) begin
            $error("fuel_level: expected %0d, got %0d", want.fuel_level, got.fuel_level);
            fail_count++;
          end
          if (got.fields_converted != want.fields_converted) begin
            $error("fields_converted: expected %0d, got %0d",
                   want.fields_converted, got.fields_converted);
            fail_count++;
          end
        end
      end
      if (byte_taken) begin
        bytes_in++;
        if (parse_byte(s_tdata, predicted)) begin
          results_due.push_back(predicted);
          conv_hist[predicted.fields_converted]++;
        end
      end
      if (byte_taken || (m_tvalid && m_tready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Watchdog: no transfer for %0d cycles, %0d results outstanding",
                 quiet_cycles, results_due.size());
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  initial begin
    rst = 1'b1;
    build_text();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    while (bytes_in < total_bytes || results_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Sent %0d bytes in %0d random lines plus directed ones; %0d results checked.",
             bytes_in, lines_built, results_seen);
    $display("Lines by fields converted: 0:%0d 1:%0d 2:%0d 3:%0d, %0d mismatches.",
             conv_hist[0], conv_hist[1], conv_hist[2], conv_hist[3], fail_count);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
